// File: rtl/gn3d_pkg.sv
// shared constants, permutation table and gradient helpers for the gradient noise unit
package gn3d_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 24;
    localparam int OUT_W      = 18;
    localparam int CELL_BITS  = (COORD_W - FRAC_BITS) < 8 ? (COORD_W - FRAC_BITS) : 8;
    // offsets t or t - S need FRAC_BITS + 1 signed bits, gradients reach +2S so two more
    localparam int OFS_W      = FRAC_BITS + 1;
    localparam int GRAD_W     = FRAC_BITS + 3;
    localparam int FADE_W     = FRAC_BITS;
    localparam int INNER_W    = FRAC_BITS + 4;
    localparam int LERP_W     = FRAC_BITS + 4;
    localparam int STAGES     = 12;

    localparam logic signed [LERP_W-1:0] OUT_MAX = LERP_W'(131071);
    localparam logic signed [LERP_W-1:0] OUT_MIN = -LERP_W'(131072);

    typedef logic [7:0] t_byte;
    typedef logic signed [GRAD_W-1:0] t_grad;
    typedef logic signed [LERP_W-1:0] t_val;

    function automatic t_byte perm(input t_byte i);
        t_byte r;
        case (i)
            8'd0: r = 8'd151; 8'd1: r = 8'd160; 8'd2: r = 8'd137; 8'd3: r = 8'd91;
            8'd4: r = 8'd90; 8'd5: r = 8'd15; 8'd6: r = 8'd131; 8'd7: r = 8'd13;
            8'd8: r = 8'd201; 8'd9: r = 8'd95; 8'd10: r = 8'd96; 8'd11: r = 8'd53;
            8'd12: r = 8'd194; 8'd13: r = 8'd233; 8'd14: r = 8'd7; 8'd15: r = 8'd225;
            8'd16: r = 8'd140; 8'd17: r = 8'd36; 8'd18: r = 8'd103; 8'd19: r = 8'd30;
            8'd20: r = 8'd69; 8'd21: r = 8'd142; 8'd22: r = 8'd8; 8'd23: r = 8'd99;
            8'd24: r = 8'd37; 8'd25: r = 8'd240; 8'd26: r = 8'd21; 8'd27: r = 8'd10;
            8'd28: r = 8'd23; 8'd29: r = 8'd190; 8'd30: r = 8'd6; 8'd31: r = 8'd148;
            8'd32: r = 8'd247; 8'd33: r = 8'd120; 8'd34: r = 8'd234; 8'd35: r = 8'd75;
            8'd36: r = 8'd0; 8'd37: r = 8'd26; 8'd38: r = 8'd197; 8'd39: r = 8'd62;
            8'd40: r = 8'd94; 8'd41: r = 8'd252; 8'd42: r = 8'd219; 8'd43: r = 8'd203;
            8'd44: r = 8'd117; 8'd45: r = 8'd35; 8'd46: r = 8'd11; 8'd47: r = 8'd32;
            8'd48: r = 8'd57; 8'd49: r = 8'd177; 8'd50: r = 8'd33; 8'd51: r = 8'd88;
            8'd52: r = 8'd237; 8'd53: r = 8'd149; 8'd54: r = 8'd56; 8'd55: r = 8'd87;
            8'd56: r = 8'd174; 8'd57: r = 8'd20; 8'd58: r = 8'd125; 8'd59: r = 8'd136;
            8'd60: r = 8'd171; 8'd61: r = 8'd168; 8'd62: r = 8'd68; 8'd63: r = 8'd175;
            8'd64: r = 8'd74; 8'd65: r = 8'd165; 8'd66: r = 8'd71; 8'd67: r = 8'd134;
            8'd68: r = 8'd139; 8'd69: r = 8'd48; 8'd70: r = 8'd27; 8'd71: r = 8'd166;
            8'd72: r = 8'd77; 8'd73: r = 8'd146; 8'd74: r = 8'd158; 8'd75: r = 8'd231;
            8'd76: r = 8'd83; 8'd77: r = 8'd111; 8'd78: r = 8'd229; 8'd79: r = 8'd122;
            8'd80: r = 8'd60; 8'd81: r = 8'd211; 8'd82: r = 8'd133; 8'd83: r = 8'd230;
            8'd84: r = 8'd220; 8'd85: r = 8'd105; 8'd86: r = 8'd92; 8'd87: r = 8'd41;
            8'd88: r = 8'd55; 8'd89: r = 8'd46; 8'd90: r = 8'd245; 8'd91: r = 8'd40;
            8'd92: r = 8'd244; 8'd93: r = 8'd102; 8'd94: r = 8'd143; 8'd95: r = 8'd54;
            8'd96: r = 8'd65; 8'd97: r = 8'd25; 8'd98: r = 8'd63; 8'd99: r = 8'd161;
            8'd100: r = 8'd1; 8'd101: r = 8'd216; 8'd102: r = 8'd80; 8'd103: r = 8'd73;
            8'd104: r = 8'd209; 8'd105: r = 8'd76; 8'd106: r = 8'd132; 8'd107: r = 8'd187;
            8'd108: r = 8'd208; 8'd109: r = 8'd89; 8'd110: r = 8'd18; 8'd111: r = 8'd169;
            8'd112: r = 8'd200; 8'd113: r = 8'd196; 8'd114: r = 8'd135; 8'd115: r = 8'd130;
            8'd116: r = 8'd116; 8'd117: r = 8'd188; 8'd118: r = 8'd159; 8'd119: r = 8'd86;
            8'd120: r = 8'd164; 8'd121: r = 8'd100; 8'd122: r = 8'd109; 8'd123: r = 8'd198;
            8'd124: r = 8'd173; 8'd125: r = 8'd186; 8'd126: r = 8'd3; 8'd127: r = 8'd64;
            8'd128: r = 8'd52; 8'd129: r = 8'd217; 8'd130: r = 8'd226; 8'd131: r = 8'd250;
            8'd132: r = 8'd124; 8'd133: r = 8'd123; 8'd134: r = 8'd5; 8'd135: r = 8'd202;
            8'd136: r = 8'd38; 8'd137: r = 8'd147; 8'd138: r = 8'd118; 8'd139: r = 8'd126;
            8'd140: r = 8'd255; 8'd141: r = 8'd82; 8'd142: r = 8'd85; 8'd143: r = 8'd212;
            8'd144: r = 8'd207; 8'd145: r = 8'd206; 8'd146: r = 8'd59; 8'd147: r = 8'd227;
            8'd148: r = 8'd47; 8'd149: r = 8'd16; 8'd150: r = 8'd58; 8'd151: r = 8'd17;
            8'd152: r = 8'd182; 8'd153: r = 8'd189; 8'd154: r = 8'd28; 8'd155: r = 8'd42;
            8'd156: r = 8'd223; 8'd157: r = 8'd183; 8'd158: r = 8'd170; 8'd159: r = 8'd213;
            8'd160: r = 8'd119; 8'd161: r = 8'd248; 8'd162: r = 8'd152; 8'd163: r = 8'd2;
            8'd164: r = 8'd44; 8'd165: r = 8'd154; 8'd166: r = 8'd163; 8'd167: r = 8'd70;
            8'd168: r = 8'd221; 8'd169: r = 8'd153; 8'd170: r = 8'd101; 8'd171: r = 8'd155;
            8'd172: r = 8'd167; 8'd173: r = 8'd43; 8'd174: r = 8'd172; 8'd175: r = 8'd9;
            8'd176: r = 8'd129; 8'd177: r = 8'd22; 8'd178: r = 8'd39; 8'd179: r = 8'd253;
            8'd180: r = 8'd19; 8'd181: r = 8'd98; 8'd182: r = 8'd108; 8'd183: r = 8'd110;
            8'd184: r = 8'd79; 8'd185: r = 8'd113; 8'd186: r = 8'd224; 8'd187: r = 8'd232;
            8'd188: r = 8'd178; 8'd189: r = 8'd185; 8'd190: r = 8'd112; 8'd191: r = 8'd104;
            8'd192: r = 8'd218; 8'd193: r = 8'd246; 8'd194: r = 8'd97; 8'd195: r = 8'd228;
            8'd196: r = 8'd251; 8'd197: r = 8'd34; 8'd198: r = 8'd242; 8'd199: r = 8'd193;
            8'd200: r = 8'd238; 8'd201: r = 8'd210; 8'd202: r = 8'd144; 8'd203: r = 8'd12;
            8'd204: r = 8'd191; 8'd205: r = 8'd179; 8'd206: r = 8'd162; 8'd207: r = 8'd241;
            8'd208: r = 8'd81; 8'd209: r = 8'd51; 8'd210: r = 8'd145; 8'd211: r = 8'd235;
            8'd212: r = 8'd249; 8'd213: r = 8'd14; 8'd214: r = 8'd239; 8'd215: r = 8'd107;
            8'd216: r = 8'd49; 8'd217: r = 8'd192; 8'd218: r = 8'd214; 8'd219: r = 8'd31;
            8'd220: r = 8'd181; 8'd221: r = 8'd199; 8'd222: r = 8'd106; 8'd223: r = 8'd157;
            8'd224: r = 8'd184; 8'd225: r = 8'd84; 8'd226: r = 8'd204; 8'd227: r = 8'd176;
            8'd228: r = 8'd115; 8'd229: r = 8'd121; 8'd230: r = 8'd50; 8'd231: r = 8'd45;
            8'd232: r = 8'd127; 8'd233: r = 8'd4; 8'd234: r = 8'd150; 8'd235: r = 8'd254;
            8'd236: r = 8'd138; 8'd237: r = 8'd236; 8'd238: r = 8'd205; 8'd239: r = 8'd93;
            8'd240: r = 8'd222; 8'd241: r = 8'd114; 8'd242: r = 8'd67; 8'd243: r = 8'd29;
            8'd244: r = 8'd24; 8'd245: r = 8'd72; 8'd246: r = 8'd243; 8'd247: r = 8'd141;
            8'd248: r = 8'd128; 8'd249: r = 8'd195; 8'd250: r = 8'd78; 8'd251: r = 8'd66;
            8'd252: r = 8'd215; 8'd253: r = 8'd61; 8'd254: r = 8'd156; 8'd255: r = 8'd180;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // twelve-direction gradient dot product, hash low nibble selects the direction
    function automatic t_grad grad(input logic [3:0] h, input logic signed [OFS_W-1:0] x,
                                   input logic signed [OFS_W-1:0] y,
                                   input logic signed [OFS_W-1:0] z);
        t_grad u;
        t_grad v;
        u = (h < 4'd8) ? GRAD_W'(x) : GRAD_W'(y);
        v = (h < 4'd4) ? GRAD_W'(y) : ((h == 4'd12 || h == 4'd14) ? GRAD_W'(x) : GRAD_W'(z));
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

endpackage

// File: rtl/gn3d_lerp.sv
// registered linear blend a + floor(f * (b - a) / S)
module gn3d_lerp (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [gn3d_pkg::FADE_W-1:0]        i_f,
    input  gn3d_pkg::t_val                     i_a,
    input  gn3d_pkg::t_val                     i_b,
    output gn3d_pkg::t_val                     o_y
);
    localparam int PW = gn3d_pkg::LERP_W + gn3d_pkg::FADE_W + 2;

    logic signed [PW-1:0] w_prod;
    gn3d_pkg::t_val       w_diff;

    // arithmetic shift is floor toward minus infinity
    assign w_diff = i_b - i_a;
    assign w_prod = $signed({1'b0, i_f}) * w_diff;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_y <= i_a + gn3d_pkg::LERP_W'(w_prod >>> gn3d_pkg::FRAC_BITS);
        end
    end
endmodule

// File: rtl/gradient_noise_3d_unit.sv
// top level of the 3d gradient noise pipeline
// 12 register stages, from the input split to the saturated output
// throughput: one point per cycle; the whole pipeline holds on output stall
// stage depth is set by one multiplier per stage in the fade and blend chain
// reset: synchronous active-low, clears the stage valid bits only
// the permutation table is constant logic, looked up in three hash stages
module gradient_noise_3d_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // x_coord[23:0], y_coord[47:24], z_coord[71:48]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // noise_value[17:0], zero fill above
);
    localparam int FB = gn3d_pkg::FRAC_BITS;
    localparam int FW = gn3d_pkg::FADE_W;
    localparam int OW = gn3d_pkg::OFS_W;
    localparam int IW = gn3d_pkg::INNER_W;
    localparam int CB = gn3d_pkg::CELL_BITS;
    localparam int NS = gn3d_pkg::STAGES;
    localparam logic [FB+3:0] TEN_S = (FB+4)'(10) << FB;

    logic [NS-1:0] r_vld;
    logic          w_en;

    // global stall: whole pipeline advances only when the output slot frees
    assign w_en = !r_vld[NS-1] || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], s_axis_tvalid};
        end
    end

    // ---------- stage 1: split ----------
    logic [2:0][FB-1:0] r1_t;
    logic [2:0][7:0]    r1_c;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_t[k] <= s_axis_tdata[k*24 +: FB];
                r1_c[k] <= 8'(s_axis_tdata[k*24+FB +: CB]);
            end
        end
    end

    // ---------- fade chain: stage 2..5 ----------
    // s2: t^2 ; s3: sq/S, inner ; s4: sq*t ; s5: cube*inner ; carry t
    logic [2:0][FB-1:0] r2_t, r3_t, r4_t;
    logic [2:0][2*FB-1:0] r2_sq;
    logic [2:0][FB-1:0] r3_sqs;
    logic [2:0][IW-1:0] r3_in, r4_in;
    logic [2:0][2*FB-1:0] r4_cb;
    logic [2:0][FW-1:0] r5_f, r6_f, r7_f;
    logic [2:0][IW+FB-1:0] w4_prod;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r2_t[k]   <= r1_t[k];
                r2_sq[k]  <= r1_t[k] * r1_t[k];
                r3_t[k]   <= r2_t[k];
                r3_sqs[k] <= r2_sq[k][2*FB-1:FB];
                // inner = (6t^2 - 15tS + 10S^2)/S = 6sq/S - 15t + 10S, exact floor
                r3_in[k]  <= IW'((({3'b0, r2_sq[k]} * 35'd6) >> FB)
                             - (IW'(r2_t[k]) * IW'(15)) + IW'(TEN_S));
                r4_t[k]   <= r3_t[k];
                r4_cb[k]  <= r3_sqs[k] * r3_t[k];
                r4_in[k]  <= r3_in[k];
                r5_f[k]   <= FW'(w4_prod[k] >> FB);
                r6_f[k] <= r5_f[k]; r7_f[k] <= r6_f[k];
            end
        end
    end
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w4_prod[k] = (IW+FB)'(r4_cb[k][2*FB-1:FB]) * (IW+FB)'(r4_in[k]);
        end
    end

    // ---------- hash chain: stages 2..4 ----------
    logic [7:0] r2_a, r2_b, r2_z;
    logic [7:0] r3_aa, r3_ab, r3_ba, r3_bb;
    logic [7:0] r4_h [8];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_a  <= gn3d_pkg::perm(r1_c[0]) + r1_c[1];
            r2_b  <= gn3d_pkg::perm(r1_c[0] + 8'd1) + r1_c[1];
            r2_z  <= r1_c[2];
            r3_aa <= gn3d_pkg::perm(r2_a) + r2_z;
            r3_ab <= gn3d_pkg::perm(r2_a + 8'd1) + r2_z;
            r3_ba <= gn3d_pkg::perm(r2_b) + r2_z;
            r3_bb <= gn3d_pkg::perm(r2_b + 8'd1) + r2_z;
            // corner order: bit0 x, bit1 y, bit2 z
            r4_h[0] <= gn3d_pkg::perm(r3_aa);
            r4_h[1] <= gn3d_pkg::perm(r3_ba);
            r4_h[2] <= gn3d_pkg::perm(r3_ab);
            r4_h[3] <= gn3d_pkg::perm(r3_bb);
            r4_h[4] <= gn3d_pkg::perm(r3_aa + 8'd1);
            r4_h[5] <= gn3d_pkg::perm(r3_ba + 8'd1);
            r4_h[6] <= gn3d_pkg::perm(r3_ab + 8'd1);
            r4_h[7] <= gn3d_pkg::perm(r3_bb + 8'd1);
        end
    end

    // ---------- stage 5: gradients from t delayed to r4 ----------
    gn3d_pkg::t_val r5_g [8];
    logic signed [OW-1:0] w_o0 [3];
    logic signed [OW-1:0] w_o1 [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_o0[k] = $signed({1'b0, r4_t[k]});
            w_o1[k] = $signed({1'b0, r4_t[k]}) - $signed(OW'(1) << FB);
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 8; c++) begin
                r5_g[c] <= gn3d_pkg::LERP_W'(gn3d_pkg::grad(r4_h[c][3:0],
                    c[0] ? w_o1[0] : w_o0[0],
                    c[1] ? w_o1[1] : w_o0[1],
                    c[2] ? w_o1[2] : w_o0[2]));
            end
        end
    end

    // ---------- stage 6: four x blends (u = fade x available at r5) ----------
    gn3d_pkg::t_val w6 [4];
    gn3d_pkg::t_val w7 [2];
    gn3d_pkg::t_val w8;
    genvar gi;
    generate
        for (gi = 0; gi < 4; gi++) begin : g_lx
            gn3d_lerp u_lx (.i_clk(i_clk), .i_en(w_en), .i_f(r5_f[0]),
                            .i_a(r5_g[2*gi]), .i_b(r5_g[2*gi+1]), .o_y(w6[gi]));
        end
        for (gi = 0; gi < 2; gi++) begin : g_ly
            gn3d_lerp u_ly (.i_clk(i_clk), .i_en(w_en), .i_f(r6_f[1]),
                            .i_a(w6[2*gi]), .i_b(w6[2*gi+1]), .o_y(w7[gi]));
        end
    endgenerate
    gn3d_lerp u_lz (.i_clk(i_clk), .i_en(w_en), .i_f(r7_f[2]),
                    .i_a(w7[0]), .i_b(w7[1]), .o_y(w8));

    // delay to the output stage, saturate at the last
    gn3d_pkg::t_val r9_v, r10_v, r11_v;
    logic [gn3d_pkg::OUT_W-1:0] r12_o;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_v  <= w8;
            r10_v <= r9_v;
            r11_v <= r10_v;
            if (r11_v > gn3d_pkg::OUT_MAX) begin
                r12_o <= gn3d_pkg::OUT_W'(gn3d_pkg::OUT_MAX);
            end else if (r11_v < gn3d_pkg::OUT_MIN) begin
                r12_o <= gn3d_pkg::OUT_W'(gn3d_pkg::OUT_MIN);
            end else begin
                r12_o <= gn3d_pkg::OUT_W'(r11_v);
            end
        end
    end

    assign m_axis_tvalid = r_vld[NS-1];
    assign m_axis_tdata  = {6'd0, r12_o};
endmodule

// File: verif/tb_gradient_noise_3d_unit.sv
// self-checking testbench for the 3d gradient noise unit: directed table plus random points
module tb_gradient_noise_3d_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  SCALE_ONE   = 1 << gn3d_pkg::FRAC_BITS;
    localparam int  IDLE_LIMIT  = 5000;
    localparam int  RAND_POINTS = 800;
    localparam int  DRAIN_WAIT  = 4 * gn3d_pkg::STAGES;

    typedef struct {
        logic [23:0] x;
        logic [23:0] y;
        logic [23:0] z;
        bit          has_value;
        logic [17:0] value;
    } t_point;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    logic [17:0] noise_queue[$];
    int          mismatches;
    int          idle_cycles;
    bit          rx_steady;
    bit          tx_steady;

    gradient_noise_3d_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // x_coord[23:0], y_coord[47:24], z_coord[71:48]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // noise_value[17:0], zero fill above
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic longint floor_scale(input longint v);
        if (v >= 0)
            return v >>> gn3d_pkg::FRAC_BITS;
        return -((-v + SCALE_ONE - 1) >>> gn3d_pkg::FRAC_BITS);
    endfunction

    function automatic longint quintic(input longint t);
        longint one;
        longint inner;
        longint cube;
        one = SCALE_ONE;
        inner = (6 * t * t - 15 * t * one + 10 * one * one) >>> gn3d_pkg::FRAC_BITS;
        cube = (((t * t) >>> gn3d_pkg::FRAC_BITS) * t) >>> gn3d_pkg::FRAC_BITS;
        return (cube * inner) >>> gn3d_pkg::FRAC_BITS;
    endfunction

    function automatic longint corner_dot(input int hash, input longint dx, input longint dy,
                                          input longint dz);
        int     h;
        longint a;
        longint b;
        h = hash & 15;
        a = (h < 8) ? dx : dy;
        b = (h < 4) ? dy : ((h == 12 || h == 14) ? dx : dz);
        return ((h & 1) ? -a : a) + ((h & 2) ? -b : b);
    endfunction

    function automatic longint blend(input longint f, input longint a, input longint b);
        return a + floor_scale(f * (b - a));
    endfunction

    function automatic int hashed(input int i);
        return int'(gn3d_pkg::perm(gn3d_pkg::t_byte'(i & 255)));
    endfunction

    function automatic logic [17:0] noise_at(input logic [23:0] px, input logic [23:0] py,
                                             input logic [23:0] pz);
        int     cx, cy, cz, ha, hb, aa, ab, ba, bb;
        longint fx, fy, fz, u, v, w, fx1, fy1, fz1, lo, hi, r;
        cx = int'((px >> gn3d_pkg::FRAC_BITS) & 24'hff);
        cy = int'((py >> gn3d_pkg::FRAC_BITS) & 24'hff);
        cz = int'((pz >> gn3d_pkg::FRAC_BITS) & 24'hff);
        fx = longint'(px) & (SCALE_ONE - 1);
        fy = longint'(py) & (SCALE_ONE - 1);
        fz = longint'(pz) & (SCALE_ONE - 1);
        u = quintic(fx);
        v = quintic(fy);
        w = quintic(fz);
        fx1 = fx - SCALE_ONE;
        fy1 = fy - SCALE_ONE;
        fz1 = fz - SCALE_ONE;
        ha = hashed(cx) + cy;
        hb = hashed(cx + 1) + cy;
        aa = hashed(ha) + cz;
        ab = hashed(ha + 1) + cz;
        ba = hashed(hb) + cz;
        bb = hashed(hb + 1) + cz;
        lo = blend(v,
                   blend(u, corner_dot(hashed(aa), fx, fy, fz),
                         corner_dot(hashed(ba), fx1, fy, fz)),
                   blend(u, corner_dot(hashed(ab), fx, fy1, fz),
                         corner_dot(hashed(bb), fx1, fy1, fz)));
        hi = blend(v,
                   blend(u, corner_dot(hashed(aa + 1), fx, fy, fz1),
                         corner_dot(hashed(ba + 1), fx1, fy, fz1)),
                   blend(u, corner_dot(hashed(ab + 1), fx, fy1, fz1),
                         corner_dot(hashed(bb + 1), fx1, fy1, fz1)));
        r = blend(w, lo, hi);
        if (r > 131071)
            r = 131071;
        if (r < -131072)
            r = -131072;
        return r[17:0];
    endfunction

    // directed points; lattice corners give zero noise
    t_point directed[] = '{
        '{24'h000000, 24'h000000, 24'h000000, 1'b1, 18'h0},
        '{24'hff0000, 24'hff0000, 24'hff0000, 1'b1, 18'h0},
        '{24'h010000, 24'h020000, 24'h030000, 1'b1, 18'h0},
        '{24'hffffff, 24'hffffff, 24'hffffff, 1'b0, 18'h0},
        '{24'h00ffff, 24'h000000, 24'h000000, 1'b0, 18'h0},
        '{24'h000000, 24'h00ffff, 24'h000000, 1'b0, 18'h0},
        '{24'h000000, 24'h000000, 24'h00ffff, 1'b0, 18'h0},
        '{24'h008000, 24'h008000, 24'h008000, 1'b0, 18'h0},
        '{24'hff8000, 24'h7f8000, 24'h808000, 1'b0, 18'h0},
        '{24'haaaaaa, 24'h555555, 24'haaaaaa, 1'b0, 18'h0},
        '{24'h555555, 24'haaaaaa, 24'h555555, 1'b0, 18'h0},
        '{24'h000001, 24'h000001, 24'h000001, 1'b0, 18'h0},
        '{24'hfffffe, 24'h00fffe, 24'h80ffff, 1'b0, 18'h0},
        '{24'h12c000, 24'h344000, 24'h56e000, 1'b0, 18'h0},
        '{24'hfe4000, 24'h01c000, 24'hfe4000, 1'b0, 18'h0},
        '{24'h7fffff, 24'h800000, 24'h7fffff, 1'b0, 18'h0}
    };

    task automatic send_point(input logic [23:0] px, input logic [23:0] py,
                              input logic [23:0] pz);
        while (!tx_steady && ($urandom_range(99) < 25)) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pz, py, px};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        noise_queue.push_back(noise_at(px, py, pz));
        @(negedge i_clk);
    endtask

    // check each output transaction against the oldest expected noise value
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (noise_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output transaction: noise %h", m_axis_tdata);
            end else begin
                logic [17:0] want;
                want = noise_queue.pop_front();
                if (m_axis_tdata !== {6'b0, want}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise mismatch: expected %h got %h", {6'b0, want},
                                 m_axis_tdata);
                end
            end
        end
    end

    // watchdog on cycles with no accepted transaction
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("gradient_noise_3d_unit regression: fail");
            $finish;
        end
    end

    // output backpressure
    always @(negedge i_clk) begin
        m_axis_tready <= rx_steady ? 1'b1 : ($urandom_range(99) >= 25);
    end

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_rst_n = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        rx_steady = 1'b0;
        tx_steady = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed[k]) begin
            send_point(directed[k].x, directed[k].y, directed[k].z);
            if (directed[k].has_value && noise_queue[$] !== directed[k].value) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("lattice point %0d: predictor gives %h", k, noise_queue[$]);
            end
        end
        for (int n = 0; n < RAND_POINTS; n++) begin
            logic [23:0] rx, ry, rz;
            tx_steady = (n >= 300 && n < 450);
            rx_steady = (n >= 350 && n < 500);
            rx = 24'($urandom());
            ry = 24'($urandom());
            rz = 24'($urandom());
            // some points sit on cell edges, at full-scale fractions or in the last z cell
            case ($urandom_range(7))
                0: rx[15:0] = 16'h0000;
                1: ry[15:0] = 16'hffff;
                2: rz[23:16] = 8'hff;
                default: ;
            endcase
            send_point(rx, ry, rz);
        end
        s_axis_tvalid <= 1'b0;
        while (noise_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("gradient_noise_3d_unit regression: pass");
        else
            $display("gradient_noise_3d_unit regression: fail");
        $finish;
    end
endmodule
